// ===== hdl/rmps_pkg.sv =====
// Shared types, constants and register map of the range-minimum PID steering block.
package rmps_pkg;

    // Default widths and sizes.
    localparam int INTEGRAL_WIDTH_DEF = 40;
    localparam int FIFO_DEPTH_DEF     = 4;

    // Stream word widths.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    // Configuration port widths.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 16;

    // Item kinds carried on the slave tuser.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_RANGE_SETPOINT = 3'd0;
    localparam logic [2:0] REG_OBST_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_GAIN_P         = 3'd2;
    localparam logic [2:0] REG_GAIN_I         = 3'd3;
    localparam logic [2:0] REG_GAIN_D         = 3'd4;
    localparam logic [2:0] REG_FORWARD_SPEED  = 3'd5;
    localparam logic [2:0] REG_SPIN_RATE      = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_RANGE_SETPOINT = 16'd1000;
    localparam logic [15:0] RST_OBST_THRESHOLD = 16'd900;
    localparam logic [15:0] RST_GAIN_P         = 16'd3328;
    localparam logic [15:0] RST_GAIN_I         = 16'd77;
    localparam logic [15:0] RST_GAIN_D         = 16'd1664;
    localparam logic [15:0] RST_FORWARD_SPEED  = 16'd500;
    localparam logic [15:0] RST_SPIN_RATE      = 16'd500;

    // Saturation limits of the angular rate.
    localparam logic signed [31:0] ANG_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] ANG_MIN = 32'sh8000_0000;

    // Bound on the magnitude of the integral product before it saturates the output.
    localparam logic signed [63:0] INT_PROD_LIM = 64'sh4000_0000_0000_0000;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [15:0]        range_setpoint;
        logic [15:0]        obstacle_threshold;
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
        logic [15:0]        forward_speed;
        logic signed [15:0] spin_rate;
    } t_cfg;

endpackage

// ===== hdl/rmps_front.sv =====
// Front part: tracks the scan minimum, commits the error and runs the integral step.
module rmps_front #(
    parameter int INTEGRAL_WIDTH = rmps_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rmps_pkg::t_cfg             i_cfg,
    input  logic                       i_accept,
    input  logic                       i_req_type,
    input  logic [15:0]                i_range,
    input  logic                       i_first,
    input  logic                       i_last,
    output logic                       o_push,
    output logic [INTEGRAL_WIDTH+35:0] o_entry
);
    import rmps_pkg::*;

    localparam int W = INTEGRAL_WIDTH;
    localparam logic signed [W-1:0] INTEG_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] INTEG_MIN = {1'b1, {(W-1){1'b0}}};

    logic [15:0]          r_scan_min,     n_scan_min;
    logic                 r_scan_blocked, n_scan_blocked;
    logic                 r_obst_flag,    n_obst_flag;
    logic signed [16:0]   r_err_now,      n_err_now;
    logic signed [16:0]   r_err_prev,     n_err_prev;
    logic signed [W-1:0]  r_err_integ,    n_err_integ;

    logic                 below;
    logic signed [W:0]    integ_sum;
    logic signed [W-1:0]  integ_sat;
    logic signed [17:0]   err_diff;
    logic                 sample_acc;
    logic                 tick_acc;

    assign sample_acc = i_accept && (i_req_type == REQ_SAMPLE);
    assign tick_acc   = i_accept && (i_req_type == REQ_TICK);
    assign below      = i_range < i_cfg.obstacle_threshold;

    // Saturating integral step and error difference for a tick.
    always_comb begin
        integ_sum = (W+1)'(r_err_integ) + (W+1)'(r_err_now);
        if (integ_sum[W] != integ_sum[W-1]) begin
            integ_sat = integ_sum[W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[W-1:0];
        end
        err_diff = 18'(r_err_now) - 18'(r_err_prev);
    end

    // Next state of the scan tracker and the controller state.
    always_comb begin
        n_scan_min     = r_scan_min;
        n_scan_blocked = r_scan_blocked;
        n_obst_flag    = r_obst_flag;
        n_err_now      = r_err_now;
        n_err_prev     = r_err_prev;
        n_err_integ    = r_err_integ;
        if (sample_acc) begin
            if (i_first) begin
                n_scan_min     = i_range;
                n_scan_blocked = below;
            end else if (!r_scan_blocked) begin
                n_scan_min     = (i_range < r_scan_min) ? i_range : r_scan_min;
                n_scan_blocked = below;
            end
            if (i_last) begin
                n_err_now   = $signed({1'b0, i_cfg.range_setpoint}) -
                              $signed({1'b0, n_scan_min});
                n_obst_flag = n_scan_blocked;
            end
        end else if (tick_acc && !r_obst_flag) begin
            n_err_integ = integ_sat;
            n_err_prev  = r_err_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_min     <= '0;
            r_scan_blocked <= 1'b0;
            r_obst_flag    <= 1'b0;
            r_err_now      <= '0;
            r_err_prev     <= '0;
            r_err_integ    <= '0;
        end else begin
            r_scan_min     <= n_scan_min;
            r_scan_blocked <= n_scan_blocked;
            r_obst_flag    <= n_obst_flag;
            r_err_now      <= n_err_now;
            r_err_prev     <= n_err_prev;
            r_err_integ    <= n_err_integ;
        end
    end

    // Each tick queues one command word: obstacle, error, difference, integral.
    assign o_push  = tick_acc;
    assign o_entry = {r_obst_flag, r_err_now, err_diff, integ_sat};

    // A blocked scan keeps its minimum until a new scan starts.
    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sample_acc && !i_first && r_scan_blocked)
        |=> ($stable(r_scan_min) && r_scan_blocked))
        else $error("blocked scan changed its minimum");

    // An obstacle tick leaves the PID state alone.
    a_obst_keeps_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_acc && r_obst_flag)
        |=> ($stable(r_err_integ) && $stable(r_err_prev)))
        else $error("obstacle tick changed the PID state");

    // A clear-path tick moves the current error into the previous error.
    a_prev_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_acc && !r_obst_flag) |=> (r_err_prev == $past(r_err_now)))
        else $error("previous error not updated on tick");

endmodule

// ===== hdl/rmps_fifo.sv =====
// Short command queue between the front and back parts.
module rmps_fifo #(
    parameter int WIDTH = 76,
    parameter int DEPTH = rmps_pkg::FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import rmps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage; the head word is read ahead from the next read pointer, and a word
    // written into the head slot of an empty or emptying queue is passed through.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (i_push && (r_wr_ptr == n_rd_ptr)) begin
            r_rd_data <= i_data;
        end else begin
            r_rd_data <= r_mem[n_rd_ptr];
        end
    end

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_rd_data;

    // The front never writes a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_FULL || i_pop))
        else $error("push into a full queue");

    // The back never reads an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from an empty queue");

    // The fill count grows on a push without a pop.
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("fill count did not grow on push");

endmodule

// ===== hdl/rmps_back.sv =====
// Back part: PID products, sum, scaling, saturation and the output register.
module rmps_back #(
    parameter int INTEGRAL_WIDTH = rmps_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rmps_pkg::t_cfg             i_cfg,
    input  logic                       i_q_valid,
    input  logic [INTEGRAL_WIDTH+35:0] i_q_data,
    output logic                       o_q_pop,
    output logic                       o_m_valid,
    input  logic                       i_m_ready,
    output logic [15:0]                o_speed,
    output logic [31:0]                o_angular,
    output logic                       o_obst
);
    import rmps_pkg::*;

    localparam int W     = INTEGRAL_WIDTH;
    localparam int PI_W  = W + 17;
    localparam int CMP_W = (PI_W > 64) ? PI_W : 64;
    localparam int SUM_W = CMP_W + 1;
    localparam logic signed [CMP_W-1:0] LIM_POS = CMP_W'(INT_PROD_LIM);
    localparam logic signed [CMP_W-1:0] LIM_NEG = -LIM_POS;

    // Fields of the queued command word.
    logic signed [W-1:0] q_integ;
    logic signed [17:0]  q_diff;
    logic signed [16:0]  q_err;
    logic                q_obst;

    assign q_integ = i_q_data[W-1:0];
    assign q_diff  = i_q_data[W+17:W];
    assign q_err   = i_q_data[W+34:W+18];
    assign q_obst  = i_q_data[W+35];

    logic                   adv;
    logic                   r_s1_valid;
    logic                   r_s1_obst;
    logic signed [33:0]     r_p_prop;
    logic signed [34:0]     r_p_der;
    logic signed [PI_W-1:0] r_p_int;
    logic                   r_out_valid;
    logic [15:0]            r_out_speed, n_out_speed;
    logic signed [31:0]     r_out_ang,   n_out_ang;
    logic                   r_out_obst;

    logic signed [CMP_W-1:0] pi_ext;
    logic signed [SUM_W-1:0] pid_sum;
    logic signed [SUM_W-1:0] pid_quo;

    // The whole back pipeline moves when the output word is free or taken.
    assign adv     = !r_out_valid || i_m_ready;
    assign o_q_pop = adv && i_q_valid;

    // Stage one: the three gain products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_obst <= q_obst;
            r_p_prop  <= $signed({1'b0, i_cfg.gain_p}) * q_err;
            r_p_der   <= $signed({1'b0, i_cfg.gain_d}) * q_diff;
            r_p_int   <= $signed({1'b0, i_cfg.gain_i}) * q_integ;
        end
    end

    // Stage two: sum, floor division by 256 and saturation to 32 bits.
    always_comb begin
        pi_ext  = CMP_W'(r_p_int);
        pid_sum = SUM_W'(r_p_int) + SUM_W'(r_p_prop) + SUM_W'(r_p_der);
        pid_quo = pid_sum >>> 8;
        if (r_s1_obst) begin
            n_out_speed = '0;
            n_out_ang   = 32'(i_cfg.spin_rate);
        end else begin
            n_out_speed = i_cfg.forward_speed;
            if (pi_ext > LIM_POS) begin
                n_out_ang = ANG_MAX;
            end else if (pi_ext < LIM_NEG) begin
                n_out_ang = ANG_MIN;
            end else if (pid_quo > SUM_W'(ANG_MAX)) begin
                n_out_ang = ANG_MAX;
            end else if (pid_quo < SUM_W'(ANG_MIN)) begin
                n_out_ang = ANG_MIN;
            end else begin
                n_out_ang = pid_quo[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out_speed <= n_out_speed;
            r_out_ang   <= n_out_ang;
            r_out_obst  <= r_s1_obst;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_speed   = r_out_speed;
    assign o_angular = r_out_ang;
    assign o_obst    = r_out_obst;

    // A stalled output keeps the product stage and its contents in place.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> (r_s1_valid && $stable(r_p_int) && $stable(r_p_prop)))
        else $error("product stage lost its word during a stall");

    // A finished product stage always reaches the output register.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv) |=> r_out_valid)
        else $error("product stage word dropped");

    // An obstacle command stands still.
    a_obst_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_obst) |-> (r_out_speed == '0))
        else $error("obstacle command with nonzero speed");

endmodule

// ===== hdl/range_min_pid_steering_top.sv =====
// Top level: configuration registers, front part, command queue and back part.
// A tick's command word passes the queue, the product stage and the output register on its way to m_axis.
// Throughput: one item per cycle while the queue is not full; samples and ticks may follow each other back to back.
// The integral step runs in the front in the accept cycle; products and sum take one
// back stage each. A four-word queue lets samples go on while the output stalls.
// Reset: synchronous active-low i_rst_n clears scan, error and integral state and queue,
// and loads the registers with their default values.
module range_min_pid_steering_top #(
    parameter int INTEGRAL_WIDTH = rmps_pkg::INTEGRAL_WIDTH_DEF,
    parameter int FIFO_DEPTH     = rmps_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream of input words.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rmps_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // range_sample[15:0], first_of_scan[16]
    input  logic                            s_axis_tuser,  // req_type[0]
    input  logic                            s_axis_tlast,  // last_of_scan
    // Master stream of commands.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rmps_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // linear_speed[15:0], angular_rate[47:16]
    output logic                            m_axis_tuser,  // obstacle_active[0]
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rmps_pkg::PADDR_W-1:0]    paddr,
    input  logic [rmps_pkg::PDATA_W-1:0]    pwdata,
    output logic [rmps_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import rmps_pkg::*;

    localparam int ENTRY_W = INTEGRAL_WIDTH + 36;

    t_cfg               r_cfg;
    logic               cfg_wr;
    logic [2:0]         reg_idx;
    logic [REG_W-1:0]   wr_val;
    logic               in_accept;
    logic               q_push;
    logic [ENTRY_W-1:0] q_wdata;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_rdata;
    logic [15:0]        out_speed;
    logic [31:0]        out_ang;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign wr_val  = pwdata[REG_W-1:0];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_setpoint     <= RST_RANGE_SETPOINT;
            r_cfg.obstacle_threshold <= RST_OBST_THRESHOLD;
            r_cfg.gain_p             <= RST_GAIN_P;
            r_cfg.gain_i             <= RST_GAIN_I;
            r_cfg.gain_d             <= RST_GAIN_D;
            r_cfg.forward_speed      <= RST_FORWARD_SPEED;
            r_cfg.spin_rate          <= RST_SPIN_RATE;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RANGE_SETPOINT: r_cfg.range_setpoint     <= wr_val;
                REG_OBST_THRESHOLD: r_cfg.obstacle_threshold <= wr_val;
                REG_GAIN_P:         r_cfg.gain_p             <= wr_val;
                REG_GAIN_I:         r_cfg.gain_i             <= wr_val;
                REG_GAIN_D:         r_cfg.gain_d             <= wr_val;
                REG_FORWARD_SPEED:  r_cfg.forward_speed      <= wr_val;
                REG_SPIN_RATE:      r_cfg.spin_rate          <= wr_val;
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            REG_RANGE_SETPOINT: prdata = PDATA_W'(r_cfg.range_setpoint);
            REG_OBST_THRESHOLD: prdata = PDATA_W'(r_cfg.obstacle_threshold);
            REG_GAIN_P:         prdata = PDATA_W'(r_cfg.gain_p);
            REG_GAIN_I:         prdata = PDATA_W'(r_cfg.gain_i);
            REG_GAIN_D:         prdata = PDATA_W'(r_cfg.gain_d);
            REG_FORWARD_SPEED:  prdata = PDATA_W'(r_cfg.forward_speed);
            REG_SPIN_RATE:      prdata = PDATA_W'($unsigned(r_cfg.spin_rate));
            default:            prdata = '0;
        endcase
    end

    // Only ticks take a queue slot, but a full queue holds off every input word.
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    rmps_front #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (in_accept),
        .i_req_type (s_axis_tuser),
        .i_range    (s_axis_tdata[15:0]),
        .i_first    (s_axis_tdata[16]),
        .i_last     (s_axis_tlast),
        .o_push     (q_push),
        .o_entry    (q_wdata)
    );

    rmps_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    rmps_back #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_speed   (out_speed),
        .o_angular (out_ang),
        .o_obst    (m_axis_tuser)
    );

    assign m_axis_tdata = {out_ang, out_speed};

endmodule

// ===== tb/tb_range_min_pid_steering_top.sv =====
// Self-checking testbench for the range-minimum PID steering block.
module tb_range_min_pid_steering_top;

    import rmps_pkg::*;

    // Clock edges allowed after the last command before the block counts as idle.
    localparam int PIPE_SLACK = 6;

    // Saturation bounds of the integral accumulator.
    localparam longint INTEG_HI = (longint'(1) << (INTEGRAL_WIDTH_DEF - 1)) - 1;
    localparam longint INTEG_LO = -INTEG_HI - 1;

    // One expected steering command.
    typedef struct {
        logic [15:0]        speed;
        logic signed [31:0] rate;
        logic               obstacle;
    } t_steer_cmd;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    range_min_pid_steering_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow registers and controller state of the predictor.
    t_cfg         cfg = '{RST_RANGE_SETPOINT, RST_OBST_THRESHOLD, RST_GAIN_P, RST_GAIN_I,
                          RST_GAIN_D, RST_FORWARD_SPEED, RST_SPIN_RATE};
    logic [15:0]  scan_min = '0;
    bit           scan_blocked = 1'b0;
    bit           obstacle_seen = 1'b0;
    longint       err_now = 0;
    longint       err_prev = 0;
    longint       err_integ = 0;
    logic signed [31:0] last_rate = '0;

    t_steer_cmd   pending_cmds[$];
    int           n_errors = 0;
    int           n_checked = 0;
    int           n_words = 0;
    int           n_ticks = 0;
    int           n_reg_writes = 0;
    int           n_settings = 1;
    bit           src_idle_en = 1'b1;
    bit           sink_idle_en = 1'b1;
    int           sink_stall = 0;

    // Advance the steering model by one accepted word; a tick queues a command.
    function automatic void predict_steering(bit kind, logic [15:0] rng, bit first, bit last);
        t_steer_cmd cmd;
        longint     diff;
        longint     acc;
        longint     scaled;
        if (kind == REQ_SAMPLE) begin
            if (first) begin
                scan_min     = rng;
                scan_blocked = (rng < cfg.obstacle_threshold);
            end else if (!scan_blocked) begin
                if (rng < scan_min) scan_min = rng;
                if (rng < cfg.obstacle_threshold) scan_blocked = 1'b1;
            end
            if (last) begin
                err_now       = longint'({48'd0, cfg.range_setpoint})
                              - longint'({48'd0, scan_min});
                obstacle_seen = scan_blocked;
            end
            return;
        end
        if (!obstacle_seen) begin
            err_integ = err_integ + err_now;
            if (err_integ > INTEG_HI) err_integ = INTEG_HI;
            if (err_integ < INTEG_LO) err_integ = INTEG_LO;
            diff     = err_now - err_prev;
            err_prev = err_now;
            // The gains are Q8.8, so the exact sum is floored by 8 bits.
            acc = longint'({48'd0, cfg.gain_p}) * err_now
                + longint'({48'd0, cfg.gain_i}) * err_integ
                + longint'({48'd0, cfg.gain_d}) * diff;
            scaled = acc >>> 8;
            if (scaled > longint'(ANG_MAX)) cmd.rate = ANG_MAX;
            else if (scaled < longint'(ANG_MIN)) cmd.rate = ANG_MIN;
            else cmd.rate = scaled[31:0];
            cmd.speed    = cfg.forward_speed;
            cmd.obstacle = 1'b0;
        end else begin
            cmd.speed    = '0;
            cmd.rate     = cfg.spin_rate;
            cmd.obstacle = 1'b1;
        end
        last_rate = cmd.rate;
        pending_cmds.push_back(cmd);
    endfunction

    // Compare one accepted command word with the oldest expectation.
    function automatic void check_command();
        t_steer_cmd         want;
        logic [15:0]        got_speed;
        logic signed [31:0] got_rate;
        got_speed = m_axis_tdata[15:0];
        got_rate  = m_axis_tdata[47:16];
        if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected command word: speed %0d rate %0d obstacle %0b",
                     $time, got_speed, got_rate, m_axis_tuser);
            n_errors++;
            return;
        end
        want = pending_cmds.pop_front();
        n_checked++;
        if (got_speed !== want.speed) begin
            $display("%0t: linear_speed mismatch, expected %0d, got %0d",
                     $time, want.speed, got_speed);
            n_errors++;
        end
        if (got_rate !== want.rate) begin
            $display("%0t: angular_rate mismatch, expected %0d, got %0d",
                     $time, want.rate, got_rate);
            n_errors++;
        end
        if (m_axis_tuser !== want.obstacle) begin
            $display("%0t: obstacle_active mismatch, expected %0b, got %0b",
                     $time, want.obstacle, m_axis_tuser);
            n_errors++;
        end
    endfunction

    // Command sink: checks accepted words and stalls in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_command();
        if (sink_stall > 0) begin
            m_axis_tready <= (sink_stall == 1);
            sink_stall    <= sink_stall - 1;
        end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= $urandom_range(1, 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Drive one input word, wait for its handshake and update the predictor.
    task automatic send_word(bit kind, logic [15:0] rng, bit first, bit last);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, first, rng};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_steering(kind, rng, first, last);
        n_words++;
        if (kind == REQ_TICK) n_ticks++;
    endtask

    // A tick word with random contents in the ignored sample fields.
    task automatic send_tick();
        send_word(REQ_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Stop sending and wait until every expected command has been checked.
    task automatic wait_for_commands();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    function automatic logic [15:0] shadow_value(logic [2:0] idx);
        case (idx)
            REG_RANGE_SETPOINT: return cfg.range_setpoint;
            REG_OBST_THRESHOLD: return cfg.obstacle_threshold;
            REG_GAIN_P:         return cfg.gain_p;
            REG_GAIN_I:         return cfg.gain_i;
            REG_GAIN_D:         return cfg.gain_d;
            REG_FORWARD_SPEED:  return cfg.forward_speed;
            REG_SPIN_RATE:      return cfg.spin_rate;
            default:            return '0;
        endcase
    endfunction

    // Register read through the configuration port, checked against the shadow copy.
    task automatic read_back(logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== shadow_value(idx)) begin
            $display("%0t: register %0d read mismatch, expected %0d, got %0d",
                     $time, idx, shadow_value(idx), prdata[15:0]);
            n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register write with a setup and an access cycle, followed by a read-back.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RANGE_SETPOINT: cfg.range_setpoint     = val;
            REG_OBST_THRESHOLD: cfg.obstacle_threshold = val;
            REG_GAIN_P:         cfg.gain_p             = val;
            REG_GAIN_I:         cfg.gain_i             = val;
            REG_GAIN_D:         cfg.gain_d             = val;
            REG_FORWARD_SPEED:  cfg.forward_speed      = val;
            REG_SPIN_RATE:      cfg.spin_rate          = val;
            default: ;
        endcase
        n_reg_writes++;
        @(posedge i_clk);
        read_back(idx);
    endtask

    task automatic write_all_regs(logic [15:0] setp, logic [15:0] thr, logic [15:0] kp,
                                  logic [15:0] ki, logic [15:0] kd, logic [15:0] speed,
                                  logic [15:0] spin);
        write_reg(REG_RANGE_SETPOINT, setp);
        write_reg(REG_OBST_THRESHOLD, thr);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_FORWARD_SPEED, speed);
        write_reg(REG_SPIN_RATE, spin);
        n_settings++;
    endtask

    // Range values spread over the whole field and clustered around the decision points.
    function automatic logic [15:0] pick_range();
        int v;
        int off;
        off = $urandom_range(0, 2000);
        case ($urandom_range(0, 4))
            0:       v = $urandom_range(0, 65535);
            1:       v = int'(cfg.obstacle_threshold) + (off % 65) - 32;
            2:       v = int'(cfg.range_setpoint) + off - 1000;
            3:       v = $urandom_range(0, 1) ? 65535 : 0;
            default: v = $urandom_range(0, 4000);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    task automatic test_register_defaults();
        for (int i = REG_RANGE_SETPOINT; i <= REG_SPIN_RATE; i++) read_back(3'(i));
    endtask

    // Hand-picked scans covering each ordering rule of the scan tracker.
    task automatic test_scan_rules();
        // Ticks before any scan has been committed, with junk in the sample fields.
        send_word(REQ_TICK, 16'd0, 1'b0, 1'b0);
        send_word(REQ_TICK, 16'hFFFF, 1'b1, 1'b1);
        // A scan of one word that starts and commits at once.
        send_word(REQ_SAMPLE, 16'd1500, 1'b1, 1'b1);
        send_tick();
        // A clear scan whose minimum comes last, with the largest range inside.
        send_word(REQ_SAMPLE, 16'd2000, 1'b1, 1'b0);
        send_word(REQ_SAMPLE, 16'd1200, 1'b0, 1'b0);
        send_word(REQ_SAMPLE, 16'hFFFF, 1'b0, 1'b0);
        send_word(REQ_SAMPLE, 16'd1100, 1'b0, 1'b1);
        send_tick();
        // A sample with no start continues the stored minimum.
        send_word(REQ_SAMPLE, 16'd950, 1'b0, 1'b1);
        send_tick();
        // The blocking sample counts; later ones are ignored but the last still commits.
        send_word(REQ_SAMPLE, 16'd3000, 1'b1, 1'b0);
        send_word(REQ_SAMPLE, 16'd899, 1'b0, 1'b0);
        send_word(REQ_SAMPLE, 16'd0, 1'b0, 1'b0);
        send_word(REQ_SAMPLE, 16'd5, 1'b0, 1'b1);
        send_tick();
        send_tick();
        // A zero range blocks a fresh scan right away.
        send_word(REQ_SAMPLE, 16'd0, 1'b1, 1'b1);
        send_tick();
        // Clear again, then no new scan: the committed error stays in use.
        send_word(REQ_SAMPLE, 16'hFFFF, 1'b1, 1'b1);
        send_tick();
        send_tick();
        wait_for_commands();
    endtask

    // Mostly well-formed scans with random contents, plus stray words and torn scans.
    task automatic run_random_traffic(int n_items);
        int stop_at;
        int len;
        stop_at = n_words + n_items;
        while (n_words < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                        send_word(REQ_SAMPLE, pick_range(), k == 0, k == len - 1);
                    repeat ($urandom_range(0, 2)) send_tick();
                end
                6, 7: send_tick();
                8: send_word(REQ_SAMPLE, pick_range(), 1'($urandom), 1'($urandom));
                default: begin
                    send_word(REQ_SAMPLE, pick_range(), 1'b1, 1'b0);
                    repeat ($urandom_range(0, 3))
                        send_word(REQ_SAMPLE, pick_range(), 1'b0, 1'b0);
                end
            endcase
            // Now and then hold the sender until the output has fully drained.
            if ($urandom_range(0, 29) == 0) wait_for_commands();
        end
        wait_for_commands();
    endtask

    // Random traffic under the reset setting, both extremes and random settings.
    task automatic test_random_settings();
        run_random_traffic(60);
        write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
        run_random_traffic(50);
        write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        run_random_traffic(50);
        repeat (2) begin
            write_all_regs(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 4000)),
                           16'($urandom_range(0, 8191)), 16'($urandom_range(0, 1023)),
                           16'($urandom_range(0, 8191)), 16'($urandom),
                           16'($urandom));
            run_random_traffic(60);
        end
    endtask

    // Full gains and a constant largest error drive the integral until the rate clips high, then low.
    task automatic test_rate_saturation();
        int guard;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_all_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1234, 16'h8001);
        send_word(REQ_SAMPLE, 16'd0, 1'b1, 1'b1);
        guard = 0;
        do begin
            send_tick();
            guard++;
        end while (last_rate != ANG_MAX && guard < 600);
        repeat (3) send_tick();
        wait_for_commands();
        write_reg(REG_RANGE_SETPOINT, 16'd0);
        send_word(REQ_SAMPLE, 16'hFFFF, 1'b1, 1'b1);
        guard = 0;
        do begin
            send_tick();
            guard++;
        end while (last_rate != ANG_MIN && guard < 600);
        repeat (3) send_tick();
        wait_for_commands();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_defaults();
        test_scan_rules();
        test_random_settings();
        test_rate_saturation();
        $display("Sent %0d input words (%0d ticks) and checked %0d commands,", n_words,
                 n_ticks, n_checked);
        $display("with %0d register writes over %0d settings, rate clipped both ways.",
                 n_reg_writes, n_settings);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d commands still expected", pending_cmds.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
